/* rtl/core/fqs_pkg.sv */
package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int POS_W  = 6;

  localparam int OBUF_DEPTH = 4;
  localparam int OB_PTR_W   = $clog2(OBUF_DEPTH);
  localparam int OB_LVL_W   = $clog2(OBUF_DEPTH + 1);

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;
  localparam logic [1:0] CMD_SRCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] value;
  } fqs_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         position;
    logic                     last;
  } fqs_out_t;

  typedef struct packed {
    logic [OB_LVL_W-1:0] level;
    logic                full;
  } fqs_ob_stat_t;

  // ring slot of an offset from head, offset never exceeds depth
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [PTR_W+1:0] sum;
    sum = (PTR_W+2)'(head) + (PTR_W+2)'(off);
    if (sum >= (PTR_W+2)'(DEPTH)) begin
      sum = sum - (PTR_W+2)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* rtl/core/fqs_ram.sv */
module fqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fqs_obuf.sv */
module fqs_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  fqs_pkg::fqs_out_t      push_data,
  output fqs_pkg::fqs_ob_stat_t  stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output fqs_pkg::fqs_out_t      out_data
);

  fqs_pkg::fqs_out_t                 buf_r [fqs_pkg::OBUF_DEPTH];
  logic [fqs_pkg::OB_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [fqs_pkg::OB_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [fqs_pkg::OB_LVL_W-1:0]      level_r, level_nxt;
  logic                              pop;

  assign out_valid  = (level_r != '0);
  assign out_data   = buf_r[rd_ptr_r];
  assign pop        = out_valid & out_ready;
  assign stat.level = level_r;
  assign stat.full  = (level_r == fqs_pkg::OB_LVL_W'(fqs_pkg::OBUF_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + fqs_pkg::OB_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + fqs_pkg::OB_PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + fqs_pkg::OB_LVL_W'(1);
    end else if (!push && pop) begin
      level_nxt = level_r - fqs_pkg::OB_LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/fifo_queue_with_search_top.sv */
// bounded fifo queue of signed 32-bit words with dequeue, display and search
// in channel: in_valid/in_ready with in_data (command, value); one command per beat
// out channel: out_valid/out_ready with out_data (status, word, position, last);
//   every command gives one result beat, a display of a non-empty queue gives one
//   beat per stored entry, last marks the final beat of each command
// commands are taken one at a time; in_ready is high only between commands
// from accept, enqueue and full/empty replies are pushed to the output buffer from
//   the execute state; dequeue, display and search push the registered entry ram
//   read data from the walk state, which reads the entry ram one entry per cycle
//   while the output buffer has room; dequeue reads one entry, display reads every
//   entry, and search stops at the first match
// results go through a 4-beat output buffer; when the receiver stalls the walk
//   pauses before the buffer fills, and nothing is lost or repeated
// reset empties the queue (head and count cleared); the entry ram itself is not
//   cleared and needs no clearing pass
module fifo_queue_with_search_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqs_pkg::fqs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fqs_pkg::fqs_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [1:0]                        cmd_r, cmd_nxt;
  logic signed [fqs_pkg::WORD_W-1:0] val_r, val_nxt;
  logic [fqs_pkg::PTR_W-1:0]         head_r, head_nxt;
  logic [fqs_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [fqs_pkg::CNT_W-1:0]         lim_r, lim_nxt;
  logic [fqs_pkg::CNT_W-1:0]         iss_r, iss_nxt;
  logic [fqs_pkg::CNT_W-1:0]         rd_off_r, rd_off_nxt;
  logic                              rd_vld_r, rd_vld_nxt;

  logic                              ram_we, ram_re;
  logic [fqs_pkg::PTR_W-1:0]         ram_waddr, ram_raddr;
  logic [fqs_pkg::WORD_W-1:0]        ram_wdata, ram_rdata;

  logic                              push;
  fqs_pkg::fqs_out_t                 push_data;
  fqs_pkg::fqs_ob_stat_t             ob_stat;
  logic                              rd_last;

  assign in_ready = (state_r == S_IDLE);
  assign rd_last  = (rd_off_r == lim_r - fqs_pkg::CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    lim_nxt    = lim_r;
    iss_nxt    = iss_r;
    rd_off_nxt = rd_off_r;
    rd_vld_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = fqs_pkg::slot_of(head_r, cnt_r);
    ram_wdata  = $unsigned(val_r);
    ram_re     = 1'b0;
    ram_raddr  = fqs_pkg::slot_of(head_r, iss_r);
    push       = 1'b0;
    push_data  = '0;
    push_data.last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          val_nxt   = in_data.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (!ob_stat.full) begin
          if (cmd_r == fqs_pkg::CMD_ENQ) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
            if (cnt_r == fqs_pkg::CNT_W'(fqs_pkg::DEPTH)) begin
              push_data.status = fqs_pkg::ST_FULL;
            end else begin
              ram_we           = 1'b1;
              cnt_nxt          = cnt_r + fqs_pkg::CNT_W'(1);
              push_data.status = fqs_pkg::ST_OK;
              push_data.word   = val_r;
            end
          end else if (cnt_r == '0) begin
            push             = 1'b1;
            push_data.status = fqs_pkg::ST_EMPTY;
            state_nxt        = S_IDLE;
          end else begin
            lim_nxt   = (cmd_r == fqs_pkg::CMD_DEQ) ? fqs_pkg::CNT_W'(1) : cnt_r;
            iss_nxt   = '0;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        // keep room in the output buffer for every read in flight
        if (iss_r < lim_r &&
            (ob_stat.level + fqs_pkg::OB_LVL_W'(rd_vld_r)) <=
            fqs_pkg::OB_LVL_W'(fqs_pkg::OBUF_DEPTH - 2)) begin
          ram_re     = 1'b1;
          iss_nxt    = iss_r + fqs_pkg::CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_off_nxt = iss_r;
        end
        if (rd_vld_r) begin
          case (cmd_r)
            fqs_pkg::CMD_DEQ: begin
              push             = 1'b1;
              push_data.status = fqs_pkg::ST_OK;
              push_data.word   = $signed(ram_rdata);
              head_nxt         = fqs_pkg::slot_of(head_r, fqs_pkg::CNT_W'(1));
              cnt_nxt          = cnt_r - fqs_pkg::CNT_W'(1);
              state_nxt        = S_IDLE;
            end
            fqs_pkg::CMD_DISP: begin
              push               = 1'b1;
              push_data.status   = fqs_pkg::ST_OK;
              push_data.word     = $signed(ram_rdata);
              push_data.position = fqs_pkg::POS_W'(rd_off_r);
              push_data.last     = rd_last;
              if (rd_last) begin
                state_nxt = S_IDLE;
              end
            end
            fqs_pkg::CMD_SRCH: begin
              if (ram_rdata == $unsigned(val_r)) begin
                push               = 1'b1;
                push_data.status   = fqs_pkg::ST_OK;
                push_data.word     = val_r;
                push_data.position = fqs_pkg::POS_W'(rd_off_r);
                state_nxt          = S_IDLE;
              end else if (rd_last) begin
                push             = 1'b1;
                push_data.status = fqs_pkg::ST_MISS;
                state_nxt        = S_IDLE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    lim_r    <= lim_nxt;
    iss_r    <= iss_nxt;
    rd_off_r <= rd_off_nxt;
  end

  fqs_ram #(
    .DEPTH (fqs_pkg::DEPTH),
    .WIDTH (fqs_pkg::WORD_W),
    .AW    (fqs_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fqs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .stat      (ob_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
